>>> hw/rtl/odbd_pkg.sv
// Package for the opcode/data byte decryptor: key entry type, permutation table
// and the built-in key tables (four fixed keys and one shared key).
// Depends on nothing; used by every module of the block.
`default_nettype none

package odbd_pkg;

    localparam int KEY_DEPTH    = 128;
    localparam int SHARED_DEPTH = 131;
    localparam int PERM_COUNT   = 24;

    localparam logic [4:0] PERM_LAST = 5'd23;

    typedef struct packed {
        logic [7:0] xor_mask;
        logic [4:0] perm_idx;
    } t_key_entry;

    // Source bit positions feeding output bits 6, 4, 2 and 0.
    localparam logic [2:0] PERM_TAB [PERM_COUNT][4] = '{
        '{3'd6,3'd4,3'd2,3'd0}, '{3'd4,3'd6,3'd2,3'd0}, '{3'd2,3'd4,3'd6,3'd0},
        '{3'd0,3'd4,3'd2,3'd6}, '{3'd6,3'd2,3'd4,3'd0}, '{3'd6,3'd0,3'd2,3'd4},
        '{3'd6,3'd4,3'd0,3'd2}, '{3'd2,3'd6,3'd4,3'd0}, '{3'd4,3'd2,3'd6,3'd0},
        '{3'd4,3'd6,3'd0,3'd2}, '{3'd6,3'd0,3'd4,3'd2}, '{3'd0,3'd6,3'd4,3'd2},
        '{3'd4,3'd0,3'd6,3'd2}, '{3'd0,3'd4,3'd6,3'd2}, '{3'd6,3'd2,3'd0,3'd4},
        '{3'd2,3'd6,3'd0,3'd4}, '{3'd0,3'd6,3'd2,3'd4}, '{3'd2,3'd0,3'd6,3'd4},
        '{3'd0,3'd2,3'd6,3'd4}, '{3'd4,3'd2,3'd0,3'd6}, '{3'd2,3'd4,3'd0,3'd6},
        '{3'd4,3'd0,3'd2,3'd6}, '{3'd2,3'd0,3'd4,3'd6}, '{3'd0,3'd2,3'd4,3'd6}
    };

    localparam logic [7:0] FIXED_XOR [4][KEY_DEPTH] = '{
        '{
            8'h40,8'h10,8'h50,8'h04,8'h44,8'h14,8'h54,8'h01,8'h41,8'h11,8'h51,8'h05,
            8'h45,8'h15,8'h55,
            8'h00,8'h40,8'h10,8'h50,8'h04,8'h44,8'h14,8'h54,8'h01,8'h41,8'h11,8'h51,
            8'h05,8'h45,8'h15,8'h55,
            8'h00,8'h40,8'h10,8'h50,8'h04,8'h44,8'h14,8'h54,8'h01,8'h41,8'h11,8'h51,
            8'h05,8'h45,8'h15,8'h55,
            8'h00,8'h40,8'h10,8'h50,8'h04,8'h44,8'h14,8'h54,8'h01,8'h41,8'h11,8'h51,
            8'h05,8'h45,8'h15,8'h55,
            8'h00,8'h40,8'h10,8'h50,8'h04,8'h44,8'h14,8'h54,8'h01,8'h41,8'h11,8'h51,
            8'h05,8'h45,8'h15,8'h55,
            8'h00,8'h40,8'h10,8'h50,8'h04,8'h44,8'h14,8'h54,8'h01,8'h41,8'h11,8'h51,
            8'h05,8'h45,8'h15,8'h55,
            8'h00,8'h40,8'h10,8'h50,8'h04,8'h44,8'h14,8'h54,8'h01,8'h41,8'h11,8'h51,
            8'h05,8'h45,8'h15,8'h55,
            8'h00,8'h40,8'h10,8'h50,8'h04,8'h44,8'h14,8'h54,8'h01,8'h41,8'h11,8'h51,
            8'h05,8'h45,8'h15,8'h55,
            8'h00
        },
        '{
            8'h04,8'h54,8'h51,8'h15,8'h40,8'h44,8'h01,8'h51,8'h55,8'h10,8'h44,8'h41,
            8'h05,8'h55,8'h50,8'h14,8'h41,8'h45,8'h00,8'h50,8'h54,8'h11,8'h45,8'h40,
            8'h04,8'h54,8'h51,8'h15,8'h40,8'h44,8'h01,8'h51,8'h55,8'h10,8'h44,8'h41,
            8'h05,8'h55,8'h50,8'h14,8'h41,8'h45,8'h00,8'h50,8'h54,8'h11,8'h45,8'h40,
            8'h04,8'h54,8'h51,8'h15,8'h40,8'h44,8'h01,8'h51,8'h55,8'h10,8'h44,8'h41,
            8'h05,8'h55,8'h50,8'h14,
            8'h04,8'h54,8'h51,8'h15,8'h40,8'h44,8'h01,8'h51,8'h55,8'h10,8'h44,8'h41,
            8'h05,8'h55,8'h50,8'h14,8'h41,8'h45,8'h00,8'h50,8'h54,8'h11,8'h45,8'h40,
            8'h04,8'h54,8'h51,8'h15,8'h40,8'h44,8'h01,8'h51,8'h55,8'h10,8'h44,8'h41,
            8'h05,8'h55,8'h50,8'h14,8'h41,8'h45,8'h00,8'h50,8'h54,8'h11,8'h45,8'h40,
            8'h04,8'h54,8'h51,8'h15,8'h40,8'h44,8'h01,8'h51,8'h55,8'h10,8'h44,8'h41,
            8'h05,8'h55,8'h50,8'h14
        },
        '{
            8'h00,8'h55,8'h45,8'h05,8'h11,8'h41,8'h01,8'h14,8'h44,8'h50,8'h10,
            8'h00,8'h55,8'h15,8'h05,8'h51,8'h41,8'h01,8'h14,8'h44,8'h04,8'h10,
            8'h40,8'h55,8'h15,8'h05,8'h51,8'h11,
            8'h01,8'h54,8'h44,8'h04,8'h10,8'h40,8'h00,8'h15,8'h45,8'h51,8'h11,
            8'h01,8'h54,8'h14,8'h04,8'h50,8'h40,8'h00,8'h15,8'h45,8'h05,8'h11,
            8'h41,8'h54,8'h14,8'h04,8'h50,8'h10,
            8'h00,8'h55,8'h45,8'h05,8'h11,8'h41,8'h01,8'h14,
            8'h00,8'h55,8'h45,8'h05,8'h11,8'h41,8'h01,8'h14,8'h44,8'h50,8'h10,
            8'h00,8'h55,8'h15,8'h05,8'h51,8'h41,8'h01,8'h14,8'h44,8'h04,8'h10,
            8'h40,8'h55,8'h15,8'h05,8'h51,8'h11,
            8'h01,8'h54,8'h44,8'h04,8'h10,8'h40,8'h00,8'h15,8'h45,8'h51,8'h11,
            8'h01,8'h54,8'h14,8'h04,8'h50,8'h40,8'h00,8'h15,8'h45,8'h05,8'h11,
            8'h41,8'h54,8'h14,8'h04,8'h50,8'h10,
            8'h00,8'h55,8'h45,8'h05,8'h11,8'h41,8'h01,8'h14
        },
        '{
            8'h00,8'h45,8'h41,8'h14,8'h10,8'h55,8'h51,8'h01,8'h04,8'h40,8'h45,8'h11,
            8'h14,8'h50,
            8'h00,8'h05,8'h41,8'h44,8'h10,8'h15,8'h51,8'h54,8'h04,
            8'h00,8'h45,8'h41,8'h14,8'h10,8'h55,8'h05,8'h01,8'h44,8'h40,8'h15,8'h11,
            8'h54,8'h50,
            8'h00,8'h05,8'h41,8'h44,8'h10,8'h15,8'h51,8'h01,8'h04,
            8'h40,8'h45,8'h11,8'h14,8'h50,8'h55,8'h05,8'h01,8'h44,8'h40,8'h15,8'h11,
            8'h54,8'h04,
            8'h00,8'h45,8'h41,8'h14,8'h50,
            8'h00,8'h05,8'h41,8'h44,8'h10,8'h15,8'h51,8'h54,8'h04,
            8'h00,8'h45,8'h41,8'h14,8'h50,8'h55,8'h05,8'h01,8'h44,8'h40,8'h15,8'h11,
            8'h54,8'h50,
            8'h00,8'h05,8'h41,8'h44,8'h10,8'h55,8'h51,8'h01,8'h04,
            8'h40,8'h45,8'h11,8'h14,8'h50,8'h55,8'h05,8'h01,8'h44,8'h40,8'h15,8'h51,
            8'h54,8'h04,
            8'h00,8'h45,8'h41,8'h14,8'h10,8'h55,8'h51,8'h01,8'h04,
            8'h40,8'h45,8'h11,8'h54,8'h50,8'h00,8'h05,8'h41
        }
    };

    localparam logic [4:0] FIXED_PERM [4][KEY_DEPTH] = '{
        '{
            5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,
            5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,5'd5,
            5'd5,
            5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,
            5'd6,
            5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
            5'd7,
            5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,5'd8,
            5'd8,
            5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,5'd9,
            5'd9,
            5'd10,5'd10,5'd10,5'd10,5'd10,5'd10,5'd10,5'd10,5'd10,5'd10,5'd10,5'd10,
            5'd10,5'd10,5'd10,5'd10,
            5'd11,5'd11,5'd11,5'd11,5'd11,5'd11,5'd11,5'd11,5'd11,5'd11,5'd11,5'd11,
            5'd11,5'd11,5'd11,5'd11,
            5'd12
        },
        '{
            5'd0,5'd0,5'd0,5'd0, 5'd1,5'd1,5'd1,5'd1,5'd1, 5'd2,5'd2,5'd2,5'd2,5'd2,
            5'd3,5'd3,5'd3,5'd3, 5'd4,5'd4,5'd4,5'd4,5'd4, 5'd5,5'd5,5'd5,5'd5,5'd5,
            5'd6,5'd6,5'd6,5'd6,5'd6,
            5'd7,5'd7,5'd7,5'd7,5'd7, 5'd8,5'd8,5'd8,5'd8, 5'd9,5'd9,5'd9,5'd9,5'd9,
            5'd10,5'd10,5'd10,5'd10,5'd10, 5'd11,5'd11,5'd11,5'd11,5'd11,
            5'd12,5'd12,5'd12,5'd12,5'd12, 5'd13,5'd13,
            5'd8,5'd8,5'd8,5'd8, 5'd9,5'd9,5'd9,5'd9,5'd9, 5'd10,5'd10,5'd10,5'd10,5'd10,
            5'd11,5'd11,5'd11,5'd11, 5'd12,5'd12,5'd12,5'd12,5'd12,
            5'd13,5'd13,5'd13,5'd13,5'd13, 5'd14,5'd14,5'd14,5'd14,5'd14,
            5'd15,5'd15,5'd15,5'd15,5'd15, 5'd16,5'd16,5'd16,5'd16,
            5'd17,5'd17,5'd17,5'd17,5'd17, 5'd18,5'd18,5'd18,5'd18,5'd18,
            5'd19,5'd19,5'd19,5'd19,5'd19, 5'd20,5'd20,5'd20,5'd20,5'd20, 5'd21,5'd21
        },
        '{
            5'd2,
            5'd3,5'd5,5'd7,5'd1,5'd3,5'd5,5'd7,5'd1,5'd3,5'd5,5'd7,
            5'd0,5'd2,5'd4,5'd6,5'd0,5'd2,5'd4,5'd6,5'd0,5'd2,5'd4,
            5'd5,5'd7,5'd1,5'd3,5'd5,5'd7,5'd1,5'd3,5'd5,5'd7,5'd1,5'd3,
            5'd4,5'd6,5'd0,5'd2,5'd4,5'd6,5'd0,5'd2,5'd4,5'd6,
            5'd8,
            5'd1,5'd3,5'd5,5'd7,5'd1,5'd3,5'd5,5'd7,5'd1,5'd3,5'd5,
            5'd6,5'd0,5'd2,5'd4,5'd6,5'd0,5'd2,
            5'd10,
            5'd11,5'd13,5'd15,5'd9,5'd11,5'd13,5'd15,5'd9,5'd11,5'd13,5'd15,
            5'd8,5'd10,5'd12,5'd14,5'd8,5'd10,5'd12,5'd14,5'd8,5'd10,5'd12,
            5'd13,5'd15,5'd9,5'd11,5'd13,5'd15,5'd9,5'd11,5'd13,5'd15,5'd9,5'd11,
            5'd12,5'd14,5'd8,5'd10,5'd12,5'd14,5'd8,5'd10,5'd12,5'd14,
            5'd16,
            5'd9,5'd11,5'd13,5'd15,5'd9,5'd11,5'd13,5'd15,5'd9,5'd11,5'd13,
            5'd14,5'd8,5'd10,5'd12,5'd14,5'd8,5'd10
        },
        '{
            5'd8,5'd9,5'd11,5'd13,5'd15,5'd0,5'd2,5'd4,5'd6,
            5'd8,5'd9,5'd11,5'd13,5'd15,5'd1,5'd2,5'd4,5'd6,
            5'd8,5'd9,5'd11,5'd13,5'd15,5'd1,5'd2,5'd4,5'd6,
            5'd8,5'd9,5'd11,5'd13,5'd15,5'd1,5'd2,5'd4,5'd6,
            5'd8,5'd10,5'd11,5'd13,5'd15,5'd1,5'd2,5'd4,5'd6,
            5'd8,5'd10,5'd11,5'd13,5'd15,5'd1,5'd2,5'd4,5'd6,
            5'd8,5'd10,5'd11,5'd13,5'd15,5'd1,5'd3,5'd4,5'd6,
            5'd8,
            5'd7,5'd1,5'd2,5'd4,5'd6,5'd0,5'd1,5'd3,5'd5,
            5'd7,5'd1,5'd2,5'd4,5'd6,5'd0,5'd1,5'd3,5'd5,
            5'd7,5'd1,5'd2,5'd4,5'd6,5'd0,5'd2,5'd3,5'd5,
            5'd7,5'd1,5'd2,5'd4,5'd6,5'd0,5'd2,5'd3,5'd5,
            5'd7,5'd1,5'd2,5'd4,5'd6,5'd0,5'd2,5'd3,5'd5,
            5'd7,5'd1,5'd3,5'd4,5'd6,5'd0,5'd2,5'd3,5'd5,
            5'd7,5'd1,5'd3,5'd4,5'd6,5'd0,5'd2,5'd4,5'd5,
            5'd7
        }
    };

    localparam logic [7:0] SHARED_XOR [SHARED_DEPTH] = '{
        8'h04,8'h54,8'h44,8'h14,8'h15,8'h15,8'h51,8'h41,
        8'h41,8'h14,8'h10,8'h50,8'h15,8'h55,8'h54,8'h05,
        8'h04,8'h41,8'h51,8'h01,8'h05,8'h10,8'h55,8'h51,
        8'h05,8'h05,8'h54,8'h11,8'h45,8'h05,8'h04,8'h14,
        8'h10,8'h55,8'h01,8'h41,8'h51,8'h05,8'h55,8'h04,
        8'h45,8'h41,8'h55,8'h14,8'h45,8'h10,8'h04,8'h45,
        8'h55,8'h50,8'h40,8'h00,8'h11,8'h45,8'h15,8'h00,
        8'h01,8'h00,8'h40,8'h00,8'h01,8'h45,8'h11,8'h00,
        8'h45,8'h00,8'h44,8'h54,8'h40,8'h04,8'h05,8'h15,
        8'h15,8'h10,8'h15,8'h04,8'h01,8'h05,8'h50,8'h11,
        8'h00,8'h44,8'h44,8'h04,8'h04,8'h01,8'h50,8'h05,
        8'h51,8'h00,8'h45,8'h44,8'h50,8'h15,8'h54,8'h40,
        8'h41,8'h45,8'h40,8'h10,8'h14,8'h15,8'h40,8'h51,
        8'h50,8'h50,8'h45,8'h00,8'h10,8'h15,8'h05,8'h51,
        8'h50,8'h44,8'h01,8'h15,8'h40,8'h04,8'h01,8'h44,
        8'h50,8'h44,8'h50,8'h50,8'h50,8'h10,8'h44,8'h04,
        8'h40,8'h04,8'h10
    };

    localparam logic [4:0] SHARED_PERM [SHARED_DEPTH] = '{
        5'd7, 5'd7, 5'd12,5'd1, 5'd18,5'd11,5'd8, 5'd23,
        5'd21,5'd17,5'd0, 5'd23,5'd22,5'd0, 5'd21,5'd15,
        5'd13,5'd19,5'd21,5'd20,5'd20,5'd12,5'd13,5'd10,
        5'd20,5'd0, 5'd14,5'd18,5'd6, 5'd18,5'd3, 5'd5,
        5'd5, 5'd20,5'd20,5'd13,5'd8, 5'd0, 5'd20,5'd18,
        5'd4, 5'd14,5'd8, 5'd5, 5'd17,5'd6, 5'd22,5'd10,
        5'd0, 5'd21,5'd0, 5'd1, 5'd6, 5'd11,5'd17,5'd9,
        5'd17,5'd3, 5'd9, 5'd21,5'd0, 5'd4, 5'd16,5'd1,
        5'd13,5'd17,5'd21,5'd5, 5'd3, 5'd7, 5'd2, 5'd16,
        5'd18,5'd13,5'd6, 5'd19,5'd11,5'd23,5'd3, 5'd20,
        5'd3, 5'd2, 5'd18,5'd10,5'd18,5'd23,5'd19,5'd23,
        5'd3, 5'd15,5'd0, 5'd10,5'd5, 5'd12,5'd0, 5'd0,
        5'd11,5'd22,5'd8, 5'd14,5'd8, 5'd6, 5'd1, 5'd15,
        5'd7, 5'd11,5'd2, 5'd17,5'd10,5'd15,5'd8, 5'd21,
        5'd10,5'd0, 5'd2, 5'd6, 5'd1, 5'd1, 5'd3, 5'd1,
        5'd12,5'd18,5'd16,5'd5, 5'd0, 5'd15,5'd17,5'd15,
        5'd10,5'd20,5'd1
    };

endpackage

`default_nettype wire

>>> hw/rtl/odbd_key_rom.sv
// Key lookup: forms the key index from address and fetch kind and reads the
// selected built-in key table. Depends on odbd_pkg.
`default_nettype none

module odbd_key_rom (
    input  wire logic [2:0]           i_key_select,
    input  wire logic [14:0]          i_fetch_address,
    input  wire logic                 i_is_opcode_fetch,
    output odbd_pkg::t_key_entry      o_key
);
    import odbd_pkg::*;

    logic [5:0] row;
    logic [6:0] key_idx;
    logic [7:0] shared_idx;

    assign row = {i_fetch_address[14], i_fetch_address[12], i_fetch_address[9],
                  i_fetch_address[6], i_fetch_address[3], i_fetch_address[0]};

    // The low index bit is set for a data read, clear for an opcode fetch.
    assign key_idx    = {row, ~i_is_opcode_fetch};
    assign shared_idx = {1'b0, key_idx} + {6'd0, i_key_select[1:0]};

    always_comb begin
        if (i_key_select[2]) begin
            o_key.xor_mask = SHARED_XOR[shared_idx];
            o_key.perm_idx = SHARED_PERM[shared_idx];
        end else begin
            o_key.xor_mask = FIXED_XOR[i_key_select[1:0]][key_idx];
            o_key.perm_idx = FIXED_PERM[i_key_select[1:0]][key_idx];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/odbd_permute.sv
// Bit shuffle and XOR: reorders bits 6,4,2,0 of the cipher byte by the key's
// permutation and applies the key's XOR mask. Depends on odbd_pkg.
`default_nettype none

module odbd_permute (
    input  wire logic [7:0]           i_cipher_byte,
    input  wire odbd_pkg::t_key_entry i_key,
    output logic [7:0]                o_plain_byte
);
    import odbd_pkg::*;

    logic [4:0] perm_sel;
    logic [2:0] src_pos [4];
    logic [7:0] shuffled;

    assign perm_sel = (i_key.perm_idx > PERM_LAST) ? PERM_LAST : i_key.perm_idx;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            src_pos[i] = PERM_TAB[perm_sel][i];
        end
        shuffled    = i_cipher_byte & 8'hAA;
        shuffled[6] = i_cipher_byte[src_pos[0]];
        shuffled[4] = i_cipher_byte[src_pos[1]];
        shuffled[2] = i_cipher_byte[src_pos[2]];
        shuffled[0] = i_cipher_byte[src_pos[3]];
    end

    assign o_plain_byte = shuffled ^ i_key.xor_mask;

endmodule

`default_nettype wire

>>> hw/rtl/opcode_data_byte_decryptor.sv
// Program byte decryptor, top level. Depends on odbd_pkg, odbd_key_rom and
// odbd_permute.
// A fetch transfer is registered in the input register, decrypted by the key lookup
// and bit shuffle combinationally, and moved into the result register, which holds it
// until the consumer takes it. Each result thus passes the input register and then the
// result register; a new fetch is taken every cycle while results drain, so
// throughput is one byte per cycle.
// Input ready drops only when both the input and the result register hold a
// fetch and the consumer is not ready in that cycle. key_select resets to 0 and
// should be written only while no fetch is in flight; the write port is always
// ready.
`default_nettype none

module opcode_data_byte_decryptor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_key_select,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [14:0] i_fetch_address,
    input  wire logic        i_is_opcode_fetch,
    input  wire logic [7:0]  i_cipher_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_plain_byte
);
    import odbd_pkg::*;

    logic [2:0]  r_key_select;
    logic        r_s1_valid;
    logic [14:0] r_s1_address;
    logic        r_s1_opcode;
    logic [7:0]  r_s1_cipher;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;

    logic        s2_take;
    logic        s1_take;
    logic        n_s1_valid;
    logic        n_out_valid;
    t_key_entry  key;
    logic [7:0]  n_out_byte;

    assign o_cfg_ready = 1'b1;

    assign s2_take    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s2_take;
    assign s1_take    = i_in_valid && o_in_ready;

    assign n_s1_valid  = s1_take || (r_s1_valid && !s2_take);
    assign n_out_valid = s2_take ? r_s1_valid : r_out_valid;

    odbd_key_rom u_key_rom (
        .i_key_select      (r_key_select),
        .i_fetch_address   (r_s1_address),
        .i_is_opcode_fetch (r_s1_opcode),
        .o_key             (key)
    );

    odbd_permute u_permute (
        .i_cipher_byte (r_s1_cipher),
        .i_key         (key),
        .o_plain_byte  (n_out_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_select <= 3'd0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_key_select <= i_cfg_key_select;
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_s1_address <= i_fetch_address;
            r_s1_opcode  <= i_is_opcode_fetch;
            r_s1_cipher  <= i_cipher_byte;
        end
        if (s2_take && r_s1_valid) begin
            r_out_byte <= n_out_byte;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_plain_byte = r_out_byte;

    // A registered fetch moves to the result register whenever it has room.
    a_s1_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s2_take |=> r_out_valid)
        else $error("registered fetch did not reach the result register");

    // Input is refused only when both pipeline registers are full.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

    // A result still waiting for the consumer keeps its byte.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_byte))
        else $error("pending result lost or changed");

    // A configuration transfer lands in the key select register.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_key_select == $past(i_cfg_key_select))
        else $error("key select not updated by configuration transfer");

endmodule

`default_nettype wire

>>> test/odbd_decrypt_checker.sv
// Scoreboard for the opcode/data byte decryptor: watches the config, fetch and
// result channels, predicts each plain byte and compares it with the DUT.
// Depends on odbd_pkg for the key entry type, the permutation and key tables.
`default_nettype none

module odbd_decrypt_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_key_select,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [14:0] i_fetch_address,
    input  wire logic        i_is_opcode_fetch,
    input  wire logic [7:0]  i_cipher_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_plain_byte,
    output int               o_fail_count,
    output int               o_pending
);
    import odbd_pkg::*;

    logic [2:0] key_sel;
    logic [7:0] plain_expected [$];

    function automatic logic [7:0] decrypt_byte(
        input logic [2:0]  ksel,
        input logic [14:0] addr,
        input logic        opcode_fetch,
        input logic [7:0]  cipher
    );
        logic [6:0] key_idx;
        int         shared_idx;
        t_key_entry entry;
        logic [4:0] perm;
        logic [7:0] shuffled;
        // The low index bit is set for a data read and clear for an opcode fetch.
        key_idx = {addr[14], addr[12], addr[9], addr[6], addr[3], addr[0], ~opcode_fetch};
        if (ksel < 3'd4) begin
            entry.xor_mask = FIXED_XOR[ksel[1:0]][key_idx];
            entry.perm_idx = FIXED_PERM[ksel[1:0]][key_idx];
        end else begin
            // Settings 4..7 read the shared key at an offset of 0..3 entries.
            shared_idx     = int'(key_idx) + int'(ksel[1:0]);
            entry.xor_mask = SHARED_XOR[shared_idx];
            entry.perm_idx = SHARED_PERM[shared_idx];
        end
        perm = (entry.perm_idx > PERM_LAST) ? PERM_LAST : entry.perm_idx;
        shuffled    = cipher & 8'hAA;
        shuffled[6] = cipher[PERM_TAB[perm][0]];
        shuffled[4] = cipher[PERM_TAB[perm][1]];
        shuffled[2] = cipher[PERM_TAB[perm][2]];
        shuffled[0] = cipher[PERM_TAB[perm][3]];
        return shuffled ^ entry.xor_mask;
    endfunction

    assign o_pending = plain_expected.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_sel <= 3'd0;
            o_fail_count <= 0;
            plain_expected.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                key_sel <= i_cfg_key_select;
            end
            if (i_out_valid && i_out_ready) begin
                if (plain_expected.size() == 0) begin
                    $error("plain_byte 0x%02h arrived with no result expected", i_plain_byte);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (i_plain_byte !== plain_expected[0]) begin
                        $error("plain_byte mismatch: expected 0x%02h, actual 0x%02h",
                               plain_expected[0], i_plain_byte);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(plain_expected.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                plain_expected.push_back(decrypt_byte(key_sel, i_fetch_address,
                                                      i_is_opcode_fetch, i_cipher_byte));
            end
        end
    end

endmodule

`default_nettype wire

>>> test/tb_opcode_data_byte_decryptor.sv
// Testbench top for the opcode/data byte decryptor: clock, reset, fetch and
// key select stimulus, result back-pressure, watchdog and final verdict.
// Depends on odbd_pkg, the decryptor RTL and odbd_decrypt_checker.
`default_nettype none

module tb_opcode_data_byte_decryptor;

    localparam int IDLE_LIMIT      = 4000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int ITEMS_PER_KEY   = 62;
    localparam int PRESSURE_ITEM   = 31;
    localparam logic [2:0] KEY_FIXED_FIRST  = 3'd0;
    localparam logic [2:0] KEY_SHARED_LAST  = 3'd7;
    localparam logic [2:0] KEY_ORDER [8] = '{3'd7, 3'd4, 3'd1, 3'd0, 3'd5, 3'd2, 3'd6, 3'd3};
    // Address bits that form the key row; the rest never affect the key.
    localparam logic [14:0] ROW_BITS = 15'h5249;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_key_select = 3'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [14:0] fetch_address = 15'd0;
    logic        is_opcode_fetch = 1'b0;
    logic [7:0]  cipher_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  plain_byte;

    int fail_count;
    int pending_results;
    int send_idle_pct = 26;
    int recv_idle_pct = 75;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    opcode_data_byte_decryptor u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_key_select  (cfg_key_select),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_fetch_address   (fetch_address),
        .i_is_opcode_fetch (is_opcode_fetch),
        .i_cipher_byte     (cipher_byte),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_plain_byte      (plain_byte)
    );

    odbd_decrypt_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_key_select  (cfg_key_select),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_fetch_address   (fetch_address),
        .i_is_opcode_fetch (is_opcode_fetch),
        .i_cipher_byte     (cipher_byte),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_plain_byte      (plain_byte),
        .o_fail_count      (fail_count),
        .o_pending         (pending_results)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Ends the run if no transfer happens on any channel for too long.
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && in_ready) || (out_valid && out_ready)
                     || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_fetch(input logic [14:0] addr, input logic opcode_fetch,
                              input logic [7:0] cipher);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        fetch_address   <= addr;
        is_opcode_fetch <= opcode_fetch;
        cipher_byte     <= cipher;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_fetch();
        send_fetch(15'($urandom_range(32767)), 1'($urandom_range(1)),
                   8'($urandom_range(255)));
    endtask

    // Holds the fetch channel off until every outstanding result has drained.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    task automatic write_key_select(input logic [2:0] ksel);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid      <= 1'b1;
        cfg_key_select <= ksel;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_directed();
        logic [14:0] row_addr;
        // Extremes of every field, both fetch kinds, on the reset key.
        send_fetch(15'h0000, 1'b1, 8'h00);
        send_fetch(15'h0000, 1'b0, 8'hFF);
        send_fetch(15'h7FFF, 1'b1, 8'hFF);
        send_fetch(15'h7FFF, 1'b0, 8'h00);
        send_fetch(15'h2AAA, 1'b1, 8'h55);
        send_fetch(15'h5555, 1'b0, 8'hAA);
        // Address bits outside the row must not change the key entry.
        send_fetch(~ROW_BITS, 1'b1, 8'h5A);
        send_fetch(~ROW_BITS, 1'b0, 8'hA5);
        for (int b = 0; b < 15; b++) begin
            row_addr = 15'd1 << b;
            if ((row_addr & ROW_BITS) != 15'd0) begin
                send_fetch(row_addr, 1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
        // The last shared entry is read only with the top offset and a data read.
        write_key_select(KEY_SHARED_LAST);
        send_fetch(15'h7FFF, 1'b0, 8'h3C);
        send_fetch(15'h7FFF, 1'b1, 8'hC3);
        send_fetch(15'h0000, 1'b0, 8'h81);
        write_key_select(KEY_FIXED_FIRST);
        send_fetch(15'h7FFF, 1'b0, 8'h7E);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        for (int seg = 0; seg < 8; seg++) begin
            write_key_select(KEY_ORDER[seg]);
            if (seg == 3) begin
                send_idle_pct = 75;
                recv_idle_pct <= 26;
            end else if (seg == 6) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            for (int n = 0; n < ITEMS_PER_KEY; n++) begin
                if (seg == 1 && n == PRESSURE_ITEM) begin
                    wait_drained();
                end
                send_random_fetch();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> opcode_data_byte_decryptor.f
hw/rtl/odbd_pkg.sv
hw/rtl/odbd_key_rom.sv
hw/rtl/odbd_permute.sv
hw/rtl/opcode_data_byte_decryptor.sv
test/odbd_decrypt_checker.sv
test/tb_opcode_data_byte_decryptor.sv
